### design/spwf_pkg.sv
// ----------------------------------------------------------------------------
// spwf_pkg: shared types and constants of the sieve prime window filter
// Table geometry, register map, reset values and the types that pass between
// the bitmap engine and the query pipeline.
// ----------------------------------------------------------------------------
package spwf_pkg;

    // smallest r with r*r >= n; evaluated at elaboration only
    function automatic int ceil_sqrt(input int n);
        int r;
        r = 0;
        while (r * r < n) begin
            r = r + 1;
        end
        return r;
    endfunction

    localparam int TABLE_SIZE  = 131072;
    localparam int ADDR_W      = $clog2(TABLE_SIZE);
    // candidates i run from 2 while i*i < TABLE_SIZE
    localparam int SIEVE_LIMIT = ceil_sqrt(TABLE_SIZE);
    localparam int CAND_W      = $clog2(SIEVE_LIMIT + 1);
    // multiple counter must hold values up to TABLE_SIZE - 1 + SIEVE_LIMIT
    localparam int MULT_W      = ADDR_W + 1;

    localparam int NUM_W       = 32;
    localparam int CFG_W       = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int OUT_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 1'd1;

    localparam logic [CFG_W-1:0] WINDOW_LOW_RESET  = 17'd100;
    localparam logic [CFG_W-1:0] WINDOW_HIGH_RESET = 17'd5000;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_READ,
        ST_CHECK,
        ST_MARK,
        ST_DONE
    } t_sieve_state;

    // lookup request from the query pipeline into the bitmap
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_lookup_req;

    // bitmap status toward the query pipeline
    typedef struct packed {
        logic ready;      // sieve finished, lookups allowed
        logic composite;  // registered read data of the last lookup
    } t_bitmap_status;

endpackage

### design/spwf_bitmap.sv
// ----------------------------------------------------------------------------
// spwf_bitmap: composite bitmap memory and sieve sequencer
// Clears the bitmap, marks 0 and 1, then runs the sieve of Eratosthenes with
// one write per marking cycle. Then the read port serves query lookups.
// ----------------------------------------------------------------------------
module spwf_bitmap (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  spwf_pkg::t_lookup_req   i_req,
    output spwf_pkg::t_bitmap_status o_status
);

    // one bit per number, 1 = composite
    logic r_bitmap [spwf_pkg::TABLE_SIZE];
    logic r_rd_data;

    spwf_pkg::t_sieve_state r_state, n_state;
    logic [spwf_pkg::ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [spwf_pkg::CAND_W-1:0] r_cand, n_cand;
    logic [spwf_pkg::MULT_W-1:0] r_mult, n_mult;

    logic                        rd_en;
    logic [spwf_pkg::ADDR_W-1:0] rd_addr;
    logic                        wr_en;
    logic [spwf_pkg::ADDR_W-1:0] wr_addr;
    logic                        wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= spwf_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_cand     <= spwf_pkg::CAND_W'(2);
            r_mult     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_cand     <= n_cand;
            r_mult     <= n_mult;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_cand     = r_cand;
        n_mult     = r_mult;
        rd_en      = 1'b0;
        rd_addr    = i_req.addr;
        wr_en      = 1'b0;
        wr_addr    = r_clr_addr;
        wr_data    = 1'b0;
        unique case (r_state)
            spwf_pkg::ST_CLEAR: begin
                // 0 and 1 are not prime; everything else starts unmarked
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = (r_clr_addr < spwf_pkg::ADDR_W'(2));
                if (r_clr_addr == spwf_pkg::ADDR_W'(spwf_pkg::TABLE_SIZE - 1)) begin
                    n_state = spwf_pkg::ST_READ;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            spwf_pkg::ST_READ: begin
                if (r_cand == spwf_pkg::CAND_W'(spwf_pkg::SIEVE_LIMIT)) begin
                    n_state = spwf_pkg::ST_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = spwf_pkg::ADDR_W'(r_cand);
                    n_state = spwf_pkg::ST_CHECK;
                end
            end
            spwf_pkg::ST_CHECK: begin
                if (r_rd_data) begin
                    n_cand  = r_cand + 1'b1;
                    n_state = spwf_pkg::ST_READ;
                end else begin
                    n_mult  = spwf_pkg::MULT_W'({r_cand, 1'b0});
                    n_state = spwf_pkg::ST_MARK;
                end
            end
            spwf_pkg::ST_MARK: begin
                if (r_mult >= spwf_pkg::MULT_W'(spwf_pkg::TABLE_SIZE)) begin
                    n_cand  = r_cand + 1'b1;
                    n_state = spwf_pkg::ST_READ;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_mult[spwf_pkg::ADDR_W-1:0];
                    wr_data = 1'b1;
                    n_mult  = r_mult + spwf_pkg::MULT_W'(r_cand);
                end
            end
            spwf_pkg::ST_DONE: begin
                rd_en   = i_req.en;
                rd_addr = i_req.addr;
            end
            default: begin
                n_state = spwf_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bitmap[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next lookup so a stalled item keeps its bit
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_bitmap[rd_addr];
        end
    end

    assign o_status.ready     = (r_state == spwf_pkg::ST_DONE);
    assign o_status.composite = r_rd_data;

endmodule

### design/spwf_query.sv
// ----------------------------------------------------------------------------
// spwf_query: query pipeline
// Issues the bitmap lookup, compares against the window and table bound,
// and holds the result in an output register for the master side.
// ----------------------------------------------------------------------------
module spwf_query (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [spwf_pkg::CFG_W-1:0]    i_window_low,
    input  logic [spwf_pkg::CFG_W-1:0]    i_window_high,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [spwf_pkg::NUM_W-1:0]    i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [spwf_pkg::OUT_W-1:0]    o_m_tdata,
    output spwf_pkg::t_lookup_req         o_req,
    input  spwf_pkg::t_bitmap_status      i_status
);

    logic accept;
    logic advance;
    logic in_table;
    logic in_window;
    logic is_prime;

    logic r_s1_valid;
    logic r_s1_in_table;
    logic r_s1_in_window;

    logic r_out_valid;
    logic r_out_in_table;
    logic r_out_is_prime;
    logic r_out_selected;

    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = i_status.ready && (!r_s1_valid || advance);
    assign accept     = i_s_tvalid && o_s_tready;

    assign o_req.en   = accept;
    assign o_req.addr = i_s_tdata[spwf_pkg::ADDR_W-1:0];

    assign in_table  = i_s_tdata < spwf_pkg::NUM_W'(spwf_pkg::TABLE_SIZE);
    assign in_window = (i_s_tdata >= spwf_pkg::NUM_W'(i_window_low))
                    && (i_s_tdata <= spwf_pkg::NUM_W'(i_window_high));

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_in_table  <= in_table;
            r_s1_in_window <= in_window;
        end
    end

    assign is_prime = r_s1_in_table && !i_status.composite;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s1_valid) begin
            r_out_in_table <= r_s1_in_table;
            r_out_is_prime <= is_prime;
            r_out_selected <= is_prime && r_s1_in_window;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(spwf_pkg::OUT_W - 3){1'b0}},
                         r_out_selected, r_out_is_prime, r_out_in_table};

endmodule

### design/sieve_prime_window_filter_top.sv
// ----------------------------------------------------------------------------
// sieve_prime_window_filter_top: prime lookup with a selection window
// Classifies query numbers against a sieved primality bitmap.
// ----------------------------------------------------------------------------
// After reset the block builds its bitmap before it accepts any item: a
// clearing pass (one memory entry per cycle, which also marks 0 and 1
// composite), then the sieve, which checks each candidate below sqrt(TABLE_SIZE)
// and marks each further multiple of every unmarked candidate.
// s_tready stays low until then; configuration writes are taken at any time.
// Once ready, the block takes one item per cycle unless the output stalls,
// set by the single read port of the bitmap memory. The memory read lands
// in the lookup stage at the accepting edge; the output register loads from
// there when the output advances. A stalled output keeps one more item in
// the lookup stage before s_tready drops. Window registers are sampled when
// an item is accepted.
// ----------------------------------------------------------------------------
module sieve_prime_window_filter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [spwf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spwf_pkg::CFG_W-1:0]     i_cfg_wdata,
    // slave side: query items
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [spwf_pkg::NUM_W-1:0]     i_s_tdata,  // [31:0] query_number
    // master side: result items
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [spwf_pkg::OUT_W-1:0]     o_m_tdata   // [0] in_table, [1] is_prime,
                                                       // [2] selected, [7:3] zero
);

    logic [spwf_pkg::CFG_W-1:0] r_window_low;
    logic [spwf_pkg::CFG_W-1:0] r_window_high;

    spwf_pkg::t_lookup_req    lookup_req;
    spwf_pkg::t_bitmap_status bitmap_status;

    // window registers; an empty window (low above high) selects nothing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_low  <= spwf_pkg::WINDOW_LOW_RESET;
            r_window_high <= spwf_pkg::WINDOW_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                spwf_pkg::REG_WINDOW_LOW:  r_window_low  <= i_cfg_wdata;
                spwf_pkg::REG_WINDOW_HIGH: r_window_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // bitmap memory plus the sieve sequencer that fills it
    spwf_bitmap u_bitmap (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (lookup_req),
        .o_status (bitmap_status)
    );

    // lookup, compare and output register
    spwf_query u_query (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_window_low  (r_window_low),
        .i_window_high (r_window_high),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_req         (lookup_req),
        .i_status      (bitmap_status)
    );

endmodule

### design/spwf_checker.sv
// ----------------------------------------------------------------------------
// spwf_checker: port-level checks of the sieve prime window filter
// Watches the top-level ports and flags inconsistent result flags, nonzero
// padding, a lost or changed stalled item, or item traffic right after reset.
// ----------------------------------------------------------------------------
module spwf_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_s_tready,
    input  logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [spwf_pkg::OUT_W-1:0]     o_m_tdata
);

    // a stalled item holds its flags
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output item changed while stalled");

    // selected implies prime, prime implies in table
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (!o_m_tdata[2] || o_m_tdata[1]) && (!o_m_tdata[1] || o_m_tdata[0]))
        else $error("inconsistent result flags");

    // padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[spwf_pkg::OUT_W-1:3] == '0)
        else $error("nonzero padding in result item");

    // the bitmap is rebuilt after every reset, so no item is taken right after
    a_build: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("item path active during bitmap build");

endmodule

bind sieve_prime_window_filter_top spwf_checker u_spwf_checker (.*);

### bench/tb_sieve_prime_window_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sieve_prime_window_filter_top: self-checking bench of the prime window filter
// Sends query items in bursts with random gaps and stalls the result stream on
// a shifting pattern. Each result item is checked against a bench-side sieve
// and window compare. The window registers are rewritten between traffic
// phases: reset values, full, empty, single value and random windows.
// ----------------------------------------------------------------------------
module tb_sieve_prime_window_filter_top;

    localparam int CLK_PERIOD       = 20;
    localparam int RST_CYCLES       = 12;
    // The limit must cover the bitmap build after reset and all of the traffic,
    // with a wide margin.
    localparam int LIMIT_CYCLES     = 2_500_000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 60;

    // same bit order as o_m_tdata[2:0]
    typedef struct packed {
        logic selected;
        logic is_prime;
        logic in_table;
    } t_query_flags;

    typedef struct {
        logic [spwf_pkg::NUM_W-1:0] number;
        t_query_flags               flags;
    } t_flag_expect;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [spwf_pkg::CFG_IDX_W-1:0] i_cfg_index = spwf_pkg::REG_WINDOW_LOW;
    logic [spwf_pkg::CFG_W-1:0]     i_cfg_wdata = '0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [spwf_pkg::NUM_W-1:0]     i_s_tdata   = '0;  // [31:0] query_number
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [spwf_pkg::OUT_W-1:0]     o_m_tdata;         // [0] in_table, [1] is_prime,
                                                       // [2] selected, [7:3] zero

    // Bench copy of the bitmap and of the window registers.
    bit                         composite_map [spwf_pkg::TABLE_SIZE];
    logic [spwf_pkg::CFG_W-1:0] win_low  = spwf_pkg::WINDOW_LOW_RESET;
    logic [spwf_pkg::CFG_W-1:0] win_high = spwf_pkg::WINDOW_HIGH_RESET;

    // Query numbers not yet offered, and the flags owed for accepted queries.
    logic [spwf_pkg::NUM_W-1:0] query_backlog_q [$];
    t_flag_expect               flags_due_q [$];

    int error_count = 0;
    int n_results   = 0;
    int n_primes    = 0;
    int n_selected  = 0;
    int n_outside   = 0;
    int n_windows   = 0;

    sieve_prime_window_filter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Run the sieve: mark 0 and 1, then strike every multiple of each
    // unmarked candidate whose square still falls inside the table.
    function automatic void build_prime_map();
        int i, j;
        for (i = 0; i < spwf_pkg::TABLE_SIZE; i++) begin
            composite_map[i] = 1'b0;
        end
        composite_map[0] = 1'b1;
        composite_map[1] = 1'b1;
        for (i = 2; i * i < spwf_pkg::TABLE_SIZE; i++) begin
            if (!composite_map[i]) begin
                for (j = i + i; j < spwf_pkg::TABLE_SIZE; j += i) begin
                    composite_map[j] = 1'b1;
                end
            end
        end
    endfunction

    // Flags of one query under the window in force when it is accepted.
    function automatic t_query_flags classify_query(logic [spwf_pkg::NUM_W-1:0] number);
        t_query_flags               f;
        logic [spwf_pkg::NUM_W-1:0] lo;
        logic [spwf_pkg::NUM_W-1:0] hi;
        lo = spwf_pkg::NUM_W'(win_low);
        hi = spwf_pkg::NUM_W'(win_high);
        f.in_table = number < spwf_pkg::TABLE_SIZE;
        f.is_prime = f.in_table && !composite_map[number[spwf_pkg::ADDR_W-1:0]];
        f.selected = f.is_prime && number >= lo && number <= hi;
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Primes are rare in a flat draw. Step up to the next one so that
    // selection gets exercised often.
    function automatic logic [spwf_pkg::NUM_W-1:0] prime_at_or_above(int unsigned start);
        int unsigned n;
        for (n = start; n < spwf_pkg::TABLE_SIZE; n++) begin
            if (!composite_map[n]) begin
                return n;
            end
        end
        return start;
    endfunction

    function automatic void queue_random_queries(int count);
        logic [spwf_pkg::NUM_W-1:0] number;
        int                         k;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    number = $urandom_range(0, spwf_pkg::TABLE_SIZE - 1);
                end
                3, 4: begin
                    // arguments swap by themselves when the window is empty
                    number = prime_at_or_above($urandom_range(win_low, win_high));
                end
                5: begin
                    // one step around a window edge
                    number = spwf_pkg::NUM_W'($urandom_range(0, 1) ? win_low : win_high);
                    number = number + $urandom_range(0, 2) - 1;
                end
                6: begin
                    number = $urandom_range(0, 64);
                end
                7, 8: begin
                    number = $urandom();
                end
                default: begin
                    // straddle the end of the table
                    number = spwf_pkg::TABLE_SIZE - 4 + $urandom_range(0, 7);
                end
            endcase
            query_backlog_q.push_back(number);
        end
    endfunction

    // Write both window registers back to back. Call only when idle.
    task automatic write_window(logic [spwf_pkg::CFG_W-1:0] low_value,
                                logic [spwf_pkg::CFG_W-1:0] high_value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= spwf_pkg::REG_WINDOW_LOW;
        i_cfg_wdata <= low_value;
        @(posedge i_clk);
        i_cfg_index <= spwf_pkg::REG_WINDOW_HIGH;
        i_cfg_wdata <= high_value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_low  = low_value;
        win_high = high_value;
        n_windows++;
        @(negedge i_clk);
    endtask

    // Sample on the falling edge, away from the driver and monitor updates.
    task automatic wait_until_idle();
        do begin
            @(negedge i_clk);
        end while (query_backlog_q.size() != 0 || i_s_tvalid || flags_due_q.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence: directed checks under the reset window first, then the window
    // extremes, then random windows with biased random queries.
    // ------------------------------------------------------------------------
    initial begin
        logic [spwf_pkg::CFG_W-1:0] lo;
        logic [spwf_pkg::CFG_W-1:0] hi;
        int                         p;

        build_prime_map();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset window 100..5000. Check small numbers, both edges, the last
        // entry of the table, the first entries past it, and the top of the
        // 32-bit range. The block holds these until its bitmap is built.
        n_windows = 1;
        query_backlog_q = '{32'd0, 32'd1, 32'd2, 32'd4, 32'd99, 32'd100, 32'd101,
                            32'd4999, 32'd5000, 32'd5003, 32'd65536, 32'd65537,
                            32'd131071, 32'd131072, 32'd131073,
                            32'h8000_0000, 32'hFFFF_FFFF};
        wait_until_idle();

        // Full window: every prime in the table is selected.
        write_window('0, '1);
        query_backlog_q.push_back(32'd2);
        query_backlog_q.push_back(32'd131071);
        queue_random_queries(ITEMS_PER_PHASE);
        wait_until_idle();

        // Empty window, low above high: nothing is selected.
        write_window('1, '0);
        query_backlog_q.push_back(32'd2);
        query_backlog_q.push_back(32'd131071);
        queue_random_queries(ITEMS_PER_PHASE);
        wait_until_idle();

        // Window of a single prime.
        write_window(17'd65537, 17'd65537);
        query_backlog_q.push_back(32'd65536);
        query_backlog_q.push_back(32'd65537);
        query_backlog_q.push_back(32'd65538);
        queue_random_queries(ITEMS_PER_PHASE - 20);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            wait_until_idle();
            case (p % 3)
                0: begin
                    // unordered, so sometimes empty
                    lo = spwf_pkg::CFG_W'($urandom_range(0, spwf_pkg::TABLE_SIZE - 1));
                    hi = spwf_pkg::CFG_W'($urandom_range(0, spwf_pkg::TABLE_SIZE - 1));
                end
                1: begin
                    lo = spwf_pkg::CFG_W'($urandom_range(0, 2000));
                    hi = spwf_pkg::CFG_W'($urandom_range(lo, spwf_pkg::TABLE_SIZE - 1));
                end
                default: begin
                    // narrow window
                    lo = spwf_pkg::CFG_W'($urandom_range(0, spwf_pkg::TABLE_SIZE - 64));
                    hi = spwf_pkg::CFG_W'(lo + $urandom_range(0, 50));
                end
            endcase
            write_window(lo, hi);
            queue_random_queries(ITEMS_PER_PHASE);
        end

        wait_until_idle();
        // Let any stray result item surface before the verdict.
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d queries under %0d window settings.", n_results, n_windows);
        $display("Of these, %0d were prime, %0d selected and %0d outside the table.",
                 n_primes, n_selected, n_outside);
        if (error_count == 0) begin
            $display("tb_sieve_prime_window_filter_top: PASS");
        end else begin
            $display("tb_sieve_prime_window_filter_top: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: offer queries from the backlog in bursts of random length. After
    // each burst, idle for a random gap. About one burst in six is long, for
    // stretches of back-to-back items. Hold tvalid and tdata until accepted.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            // Record the flags owed for an accepted item, under the window now in force.
            if (i_s_tvalid && o_s_tready) begin
                flags_due_q.push_back('{number: i_s_tdata, flags: classify_query(i_s_tdata)});
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (query_backlog_q.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= query_backlog_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        gap_left   = $urandom_range(0, 8);
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result item against the oldest owed flags, and
    // drive tready. The stall pattern rotates through always ready, light
    // random stalls, heavy random stalls and tready alternating high and low.
    // Twice, while the sender is offering, hold tready low for a long stretch.
    // This fills the block and drops s_tready.
    // ------------------------------------------------------------------------
    int rx_cycle   = 0;
    int hold_left  = 0;
    int holds_done = 0;

    always @(posedge i_clk) begin
        t_flag_expect due;
        t_query_flags got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                n_results++;
                got = o_m_tdata[2:0];
                if (flags_due_q.size() == 0) begin
                    $error("result item with no query pending: tdata=%h", o_m_tdata);
                    error_count++;
                end else begin
                    due = flags_due_q.pop_front();
                    if (got.in_table !== due.flags.in_table) begin
                        $error("query %0d in_table: expected %0b, actual %0b",
                               due.number, due.flags.in_table, got.in_table);
                        error_count++;
                    end
                    if (got.is_prime !== due.flags.is_prime) begin
                        $error("query %0d is_prime: expected %0b, actual %0b",
                               due.number, due.flags.is_prime, got.is_prime);
                        error_count++;
                    end
                    if (got.selected !== due.flags.selected) begin
                        $error("query %0d selected: expected %0b, actual %0b",
                               due.number, due.flags.selected, got.selected);
                        error_count++;
                    end
                    if (due.flags.is_prime) begin
                        n_primes++;
                    end
                    if (due.flags.selected) begin
                        n_selected++;
                    end
                    if (!due.flags.in_table) begin
                        n_outside++;
                    end
                end
            end

            rx_cycle++;
            if (hold_left == 0 && holds_done < 2 && i_s_tvalid
                    && n_results >= 150 + holds_done * 250) begin
                hold_left = LONG_HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case ((rx_cycle / 48) % 4)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= ($urandom_range(0, 3) != 0);
                    2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_tready <= (rx_cycle % 2 == 0);
                endcase
            end
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Timed out with %0d results received.", n_results);
        $display("tb_sieve_prime_window_filter_top: FAIL");
        $finish;
    end

endmodule

### sim.f
design/spwf_pkg.sv
design/spwf_bitmap.sv
design/spwf_query.sv
design/sieve_prime_window_filter_top.sv
design/spwf_checker.sv
bench/tb_sieve_prime_window_filter_top.sv
